// ===== design/dq_pkg.sv =====
// dq_pkg: shared types and constants of the double-ended queue.
// Used by dq_ctrl and double_ended_queue; depends on nothing.
package dq_pkg;

    localparam int DATA_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int DEPTH_DEFAULT = 1024;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SIZE       = 3'd4,
        OP_EMPTY      = 3'd5,
        OP_PEEK_FRONT = 3'd6,
        OP_PEEK_BACK  = 3'd7
    } opcode_t;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic signed [DATA_W-1:0] MINUS_ONE = -32'sd1;

    // Result description handed from the control to the output pipeline.
    typedef struct packed {
        logic                     use_ram;
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] imm;
    } rd_meta_t;

endpackage

// ===== design/dq_ram.sv =====
// dq_ram: generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/dq_ctrl.sv =====
// dq_ctrl: front index and count of the ring, opcode decode, RAM addressing.
// Depends on dq_pkg.
module dq_ctrl #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [2:0]                      opcode,
    input  logic signed [dq_pkg::DATA_W-1:0] value,
    output logic                            wr_en,
    output logic [$clog2(DEPTH)-1:0]        wr_addr,
    output logic [dq_pkg::DATA_W-1:0]       wr_data,
    output logic                            rd_en,
    output logic [$clog2(DEPTH)-1:0]        rd_addr,
    output logic                            has_result,
    output dq_pkg::rd_meta_t                meta
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);

    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             is_empty, is_full;
    logic [SUM_W-1:0] tail_raw, back_raw;
    logic [IDX_W-1:0] tail_idx, back_idx, front_dec, front_inc;
    dq_pkg::opcode_t  op;

    assign op       = dq_pkg::opcode_t'(opcode);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));

    // Slot after the back word, and the back word itself; both wrap once at most.
    assign tail_raw  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign back_raw  = tail_raw - SUM_W'(1);
    assign tail_idx  = (tail_raw >= DEPTH_S) ? IDX_W'(tail_raw - DEPTH_S) : IDX_W'(tail_raw);
    assign back_idx  = (back_raw >= DEPTH_S) ? IDX_W'(back_raw - DEPTH_S) : IDX_W'(back_raw);
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - IDX_W'(1);
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + IDX_W'(1);

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        wr_en       = 1'b0;
        wr_addr     = tail_idx;
        wr_data     = value;
        rd_en       = 1'b0;
        rd_addr     = front_reg;
        has_result  = 1'b1;
        meta.use_ram = 1'b0;
        meta.status  = dq_pkg::ST_OK;
        meta.imm     = '0;

        unique case (op)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    meta.status = dq_pkg::ST_FULL;
                end
                else
                begin
                    has_result = 1'b0;
                    wr_en      = accept;
                    count_next = count_reg + CNT_W'(1);
                    if (op == dq_pkg::OP_PUSH_FRONT)
                    begin
                        front_next = front_dec;
                        wr_addr    = front_dec;
                    end
                end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK,
            dq_pkg::OP_PEEK_FRONT, dq_pkg::OP_PEEK_BACK:
            begin
                if (is_empty)
                begin
                    meta.status = dq_pkg::ST_EMPTY;
                    meta.imm    = dq_pkg::MINUS_ONE;
                end
                else
                begin
                    meta.use_ram = 1'b1;
                    rd_en        = accept;
                    if (op == dq_pkg::OP_POP_BACK || op == dq_pkg::OP_PEEK_BACK)
                    begin
                        rd_addr = back_idx;
                    end
                    if (op == dq_pkg::OP_POP_FRONT)
                    begin
                        front_next = front_inc;
                        count_next = count_reg - CNT_W'(1);
                    end
                    else if (op == dq_pkg::OP_POP_BACK)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            dq_pkg::OP_SIZE:
            begin
                meta.imm = {{(dq_pkg::DATA_W - CNT_W){1'b0}}, count_reg};
            end
            dq_pkg::OP_EMPTY:
            begin
                meta.imm = {{(dq_pkg::DATA_W - 1){1'b0}}, is_empty};
            end
            default:
            begin
                has_result = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/double_ended_queue.sv =====
// double_ended_queue: top level; ring control, entry RAM and result pipeline.
// Depends on dq_pkg, dq_ctrl and dq_ram.
//
// Usage:
//   Input channel (opcode, value, in_valid/in_ready) takes one command per
//   transaction: push front/back, pop front/back, size, empty, peek front/back.
//   Output channel (result_value, status, out_valid/out_ready) returns one
//   result per command, except a push that fits, which returns nothing.
//   A push on a full queue drops the word and returns status full.
//   Pops and peeks on an empty queue return -1 with status empty.
// Pipeline: the RAM read and result description register at the accepting
//   edge; the output register loads from them when the RAM stage advances.
// Throughput: one command per cycle while in_ready is high; ring index and
//   count update on accept; the one RAM write/read port is used at most once.
// Reset: the queue becomes empty at once; the RAM contents are not cleared
//   and no clearing pass runs. Words are read only after they were pushed.
// Stall: while out_ready is low the output holds; one more result waits in
//   the RAM stage, after which in_ready drops until the output drains.
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [2:0]                         opcode,
    input  logic signed [dq_pkg::DATA_W-1:0]   value,
    input  logic                               in_valid,
    output logic                               in_ready,
    output logic signed [dq_pkg::DATA_W-1:0]   result_value,
    output logic [dq_pkg::STATUS_W-1:0]        status,
    output logic                               out_valid,
    input  logic                               out_ready
);

    localparam int IDX_W = $clog2(DEPTH);

    logic                        accept;
    logic                        wr_en, rd_en, has_result;
    logic [IDX_W-1:0]            wr_addr, rd_addr;
    logic [dq_pkg::DATA_W-1:0]   wr_data, rd_data;
    dq_pkg::rd_meta_t            meta;

    logic                        s1_valid_reg;
    dq_pkg::rd_meta_t            s1_meta_reg;
    logic                        s1_move;

    logic                               out_valid_reg;
    logic signed [dq_pkg::DATA_W-1:0]   result_value_reg;
    logic [dq_pkg::STATUS_W-1:0]        status_reg;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign accept   = in_valid && in_ready;

    dq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .opcode     (opcode),
        .value      (value),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .has_result (has_result),
        .meta       (meta)
    );

    dq_ram #(
        .WIDTH (dq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // RAM stage: hold the result description alongside the read in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= has_result;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= meta;
        end
    end

    // Output register: advance from the RAM stage, drop on transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            result_value_reg <= s1_meta_reg.use_ram ? $signed(rd_data) : s1_meta_reg.imm;
            status_reg       <= s1_meta_reg.status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign status       = status_reg;

endmodule
